[rtl/ccrsf_pkg.sv]
// Shared types and constants for the circle/rectangle span rasterizer.
// No dependencies; used by the top level, the span checker and the testbench top.
package ccrsf_pkg;

	localparam int ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_ROW_PITCH    = 2'd2,
		REG_FILL_COLOR   = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_ARG,
		ST_SQRT,
		ST_CLIP,
		ST_ADDR,
		ST_EMIT
	} state_t;

	localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [12:0] ROW_PITCH_RST    = 13'd640;
	localparam logic [31:0] FILL_COLOR_RST   = 32'd0;

endpackage

[rtl/ccrsf_if.sv]
// Valid/ready channel interfaces for draw commands and span results.
// Stand-alone; used by the top level, the span checker and the testbench top.
interface ccrsf_cmd_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [12:0] pos_x;
	logic signed [12:0] pos_y;
	logic signed [12:0] rect_width;
	logic [6:0]         rect_height;
	logic [5:0]         radius;

	modport source(output valid, op, pos_x, pos_y, rect_width, rect_height, radius,
		input ready);
	modport sink(input valid, op, pos_x, pos_y, rect_width, rect_height, radius,
		output ready);
endinterface

interface ccrsf_span_if;
	logic        valid;
	logic        ready;
	logic        row_visible;
	logic [23:0] span_address;
	logic [12:0] span_length;
	logic [31:0] span_color;
	logic        last_row;

	modport source(output valid, row_visible, span_address, span_length, span_color,
		last_row, input ready);
	modport sink(input valid, row_visible, span_address, span_length, span_color,
		last_row, output ready);
endinterface

[rtl/clipped_circle_rect_span_fill.sv]
// Channel  | Dir | Handshake        | Payload
// cmd      | in  | valid/ready      | op, pos_x, pos_y, rect_width, rect_height, radius
// span     | out | valid/ready      | row_visible, span_address, span_length, span_color,
//          |     |                  | last_row
// apb      | in  | psel/penable     | paddr[3:2] selects the register, pwdata, prdata
//
// A command is taken only in idle and then runs one row at a time.
// Row states: invisible ROW, EMIT; rectangle ROW, CLIP, ADDR, EMIT; circle adds
// ARG, SQRT (square root steps) after ROW; EMIT waits while the sink holds the span.
// One 13x13 multiplier serves both the circle radicand and row*pitch.
// Reset restores the register defaults and the idle state; no clearing pass.
// Depends on ccrsf_pkg, ccrsf_if and ccrsf_isqrt.
module clipped_circle_rect_span_fill #(
	parameter int MAX_ROWS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ccrsf_cmd_if.sink                  cmd,
	ccrsf_span_if.source               span,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ccrsf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int RDW = $clog2(MAX_ROWS / 2 + 1);
	localparam int AW  = 2 * RDW;

	ccrsf_pkg::state_t state_q, state_n;

	logic [12:0] fw_q, fh_q, pitch_q;
	logic [31:0] color_q;

	logic               op_q;
	logic signed [12:0] px_q;
	logic signed [12:0] rw_q;
	logic [RDW-1:0]     rad_q;
	logic [RCW-1:0]     rows_q;
	logic [RCW-1:0]     i_q;
	logic signed [14:0] row_q;
	logic               vis_q;
	logic [11:0]        xc_q;
	logic [12:0]        len_q;
	logic [23:0]        addr_q;

	logic        span_valid_q;
	logic        span_vis_q;
	logic [23:0] span_addr_q;
	logic [12:0] span_len_q;
	logic [31:0] span_color_q;
	logic        span_last_q;

	logic [6:0]         rh_cl;
	logic [5:0]         rad_cl;
	logic [RCW-1:0]     rows_in;
	logic               accept;
	logic               vis_w;
	logic               last_w;
	logic               span_free;
	logic [RCW:0]       two_rad_m;
	logic [12:0]        mul_a, mul_b;
	logic [25:0]        mul_p;
	logic               sq_start;
	logic               sq_done;
	logic [RDW-1:0]     sq_root;
	logic signed [15:0] s16, xofs_w, len_w, end_w, xc_w, lim_w, lenc_w, fw16;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q    <= ccrsf_pkg::FRAME_WIDTH_RST;
			fh_q    <= ccrsf_pkg::FRAME_HEIGHT_RST;
			pitch_q <= ccrsf_pkg::ROW_PITCH_RST;
			color_q <= ccrsf_pkg::FILL_COLOR_RST;
		end else if (psel && penable && pwrite) begin
			unique case (ccrsf_pkg::cfg_reg_t'(paddr[3:2]))
				ccrsf_pkg::REG_FRAME_WIDTH:  fw_q    <= pwdata[12:0];
				ccrsf_pkg::REG_FRAME_HEIGHT: fh_q    <= pwdata[12:0];
				ccrsf_pkg::REG_ROW_PITCH:    pitch_q <= pwdata[12:0];
				ccrsf_pkg::REG_FILL_COLOR:   color_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ccrsf_pkg::cfg_reg_t'(paddr[3:2]))
			ccrsf_pkg::REG_FRAME_WIDTH:  prdata = {19'd0, fw_q};
			ccrsf_pkg::REG_FRAME_HEIGHT: prdata = {19'd0, fh_q};
			ccrsf_pkg::REG_ROW_PITCH:    prdata = {19'd0, pitch_q};
			ccrsf_pkg::REG_FILL_COLOR:   prdata = color_q;
			default:                     prdata = '0;
		endcase
	end

	// command decode
	assign rh_cl   = (cmd.rect_height > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : cmd.rect_height;
	assign rad_cl  = (cmd.radius > 6'(MAX_ROWS / 2)) ? 6'(MAX_ROWS / 2) : cmd.radius;
	assign rows_in = cmd.op ? RCW'({rad_cl, 1'b0}) : RCW'(rh_cl);
	assign cmd.ready = (state_q == ccrsf_pkg::ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	assign vis_w     = !row_q[14] && (row_q < $signed({2'b00, fh_q}));
	assign last_w    = ((RCW+1)'(i_q) + (RCW+1)'(1)) == (RCW+1)'(rows_q);
	assign span_free = !span_valid_q || span.ready;

	// shared multiplier: radicand i*(2r-i) or row*pitch
	assign two_rad_m = (RCW+1)'({rad_q, 1'b0}) - (RCW+1)'(i_q);
	always_comb begin
		if (state_q == ccrsf_pkg::ST_ARG) begin
			mul_a = 13'(i_q);
			mul_b = 13'(two_rad_m);
		end else begin
			mul_a = row_q[12:0];
			mul_b = pitch_q;
		end
	end
	assign mul_p = mul_a * mul_b;

	assign sq_start = (state_q == ccrsf_pkg::ST_ARG);

	ccrsf_isqrt #(
		.AW(AW)
	) u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.arg   (mul_p[AW-1:0]),
		.done  (sq_done),
		.root  (sq_root)
	);

	// horizontal clip
	assign s16    = $signed(16'(sq_root));
	assign fw16   = $signed({3'b000, fw_q});
	assign xofs_w = op_q ? $signed({{3{px_q[12]}}, px_q}) - s16
		: $signed({{3{px_q[12]}}, px_q});
	assign len_w  = op_q ? (s16 <<< 1) : $signed({{3{rw_q[12]}}, rw_q});
	assign end_w  = xofs_w + len_w;
	assign xc_w   = xofs_w[15] ? 16'sd0 : xofs_w;
	assign lim_w  = (end_w >= fw16) ? fw16 : end_w;
	assign lenc_w = lim_w - xc_w;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccrsf_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ccrsf_pkg::ST_IDLE: begin
				if (accept && rows_in != '0) state_n = ccrsf_pkg::ST_ROW;
			end
			ccrsf_pkg::ST_ROW: begin
				if (!vis_w)    state_n = ccrsf_pkg::ST_EMIT;
				else if (op_q) state_n = ccrsf_pkg::ST_ARG;
				else           state_n = ccrsf_pkg::ST_CLIP;
			end
			ccrsf_pkg::ST_ARG:  state_n = ccrsf_pkg::ST_SQRT;
			ccrsf_pkg::ST_SQRT: begin
				if (sq_done) state_n = ccrsf_pkg::ST_CLIP;
			end
			ccrsf_pkg::ST_CLIP: state_n = ccrsf_pkg::ST_ADDR;
			ccrsf_pkg::ST_ADDR: state_n = ccrsf_pkg::ST_EMIT;
			ccrsf_pkg::ST_EMIT: begin
				if (span_free) state_n = last_w ? ccrsf_pkg::ST_IDLE : ccrsf_pkg::ST_ROW;
			end
			default: state_n = ccrsf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= cmd.op;
			px_q   <= cmd.pos_x;
			rw_q   <= cmd.rect_width;
			rad_q  <= RDW'(rad_cl);
			rows_q <= rows_in;
			i_q    <= '0;
			row_q  <= $signed({{2{cmd.pos_y[12]}}, cmd.pos_y})
				- $signed(cmd.op ? {9'd0, rad_cl} : 15'd0);
		end
		if (state_q == ccrsf_pkg::ST_ROW) begin
			vis_q <= vis_w;
		end
		if (state_q == ccrsf_pkg::ST_CLIP) begin
			xc_q  <= xc_w[11:0];
			len_q <= (lenc_w > 16'sd0) ? lenc_w[12:0] : 13'd0;
		end
		if (state_q == ccrsf_pkg::ST_ADDR) begin
			addr_q <= 24'(mul_p + 26'(xc_q));
		end
		if (state_q == ccrsf_pkg::ST_EMIT && span_free) begin
			i_q   <= i_q + RCW'(1);
			row_q <= row_q + 15'sd1;
		end
	end

	// span output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (state_q == ccrsf_pkg::ST_EMIT && span_free) begin
			span_valid_q <= 1'b1;
		end else if (span.ready) begin
			span_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ccrsf_pkg::ST_EMIT && span_free) begin
			span_vis_q   <= vis_q;
			span_addr_q  <= vis_q ? addr_q : 24'd0;
			span_len_q   <= vis_q ? len_q : 13'd0;
			span_color_q <= color_q;
			span_last_q  <= last_w;
		end
	end

	assign span.valid        = span_valid_q;
	assign span.row_visible  = span_vis_q;
	assign span.span_address = span_addr_q;
	assign span.span_length  = span_len_q;
	assign span.span_color   = span_color_q;
	assign span.last_row     = span_last_q;

endmodule

[rtl/ccrsf_isqrt.sv]
// Iterative integer square root, one result bit per iteration; a start while busy restarts it.
// No package dependencies; instantiated by the span rasterizer top level.
module ccrsf_isqrt #(
	parameter int AW = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [AW-1:0]     arg,
	output logic              done,
	output logic [AW/2-1:0]   root
);

	logic [AW-1:0] rem_q;
	logic [AW-1:0] res_q;
	logic [AW-1:0] bit_q;
	logic [AW-1:0] trial;
	logic          busy_q;
	logic          done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= arg;
			res_q <= '0;
			bit_q <= AW'(1) << (AW - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[AW/2-1:0];

endmodule

[rtl/ccrsf_checker.sv]
// Port-level checks for the span rasterizer, bound to its top level.
// Sees only top-level ports; no package dependencies.
module ccrsf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        cmd_op,
	input logic [6:0]  cmd_rect_height,
	input logic [5:0]  cmd_radius,
	input logic        span_valid,
	input logic        span_ready,
	input logic        span_row_visible,
	input logic [23:0] span_address,
	input logic [12:0] span_length,
	input logic        span_last_row
);

	a_span_hold: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && !span_ready |=> span_valid && $stable(span_address)
			&& $stable(span_length) && $stable(span_last_row))
		else $error("span item changed while stalled");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready
			&& ((cmd_op && cmd_radius != 6'd0) || (!cmd_op && cmd_rect_height != 7'd0))
			|=> !cmd_ready)
		else $error("ready while a nonempty command is in progress");

	a_invisible_empty: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && !span_row_visible |-> span_address == 24'd0 && span_length == 13'd0)
		else $error("invisible row carries address or length");

endmodule

bind clipped_circle_rect_span_fill ccrsf_checker u_ccrsf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.cmd_op          (cmd.op),
	.cmd_rect_height (cmd.rect_height),
	.cmd_radius      (cmd.radius),
	.span_valid      (span.valid),
	.span_ready      (span.ready),
	.span_row_visible(span.row_visible),
	.span_address    (span.span_address),
	.span_length     (span.span_length),
	.span_last_row   (span.last_row)
);

[tb/ccrsf_tb_pkg.sv]
// Testbench-side types for the span rasterizer: shape codes, row limit and
// the record of one span item. Used by span_checker and tb_top.
package ccrsf_tb_pkg;

	localparam int ROW_LIMIT = 64;

	typedef enum bit {
		SHAPE_RECT   = 1'b0,
		SHAPE_CIRCLE = 1'b1
	} shape_t;

	typedef struct packed {
		logic        row_visible;
		logic [23:0] span_address;
		logic [12:0] span_length;
		logic [31:0] span_color;
		logic        last_row;
	} span_rec_t;

endpackage

[tb/span_checker.sv]
// Span checker: follows register writes on the config bus, predicts the spans of
// every accepted draw command and compares each accepted span item in order.
// Depends on ccrsf_pkg, ccrsf_tb_pkg and the channel interfaces.
module span_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	ccrsf_cmd_if                         cmd,
	ccrsf_span_if                        span,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ccrsf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	input  logic                         pready,
	input  logic                         flush,
	output int                           fail_count,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [12:0]              frame_width;
	logic [12:0]              frame_height;
	logic [12:0]              row_pitch;
	logic [31:0]              fill_color;
	ccrsf_tb_pkg::span_rec_t  span_rows_q[$];
	int                       span_count;
	bit                       flushed;

	initial begin
		fail_count = 0;
		pending = 0;
		span_count = 0;
		flushed = 0;
	end

	task automatic report_mismatch(string msg);
		$display("mismatch: %s", msg);
		fail_count++;
	endtask

	task automatic predict_spans(ccrsf_tb_pkg::shape_t shape, int px, int py, int w, int h,
		int r);
		ccrsf_tb_pkg::span_rec_t row_rec;
		int n_rows, top_row, row, i, len, xofs, dy, radicand, half;
		if (shape == ccrsf_tb_pkg::SHAPE_RECT) begin
			n_rows = (h > ccrsf_tb_pkg::ROW_LIMIT) ? ccrsf_tb_pkg::ROW_LIMIT : h;
			top_row = py;
		end else begin
			if (r > ccrsf_tb_pkg::ROW_LIMIT / 2)
				r = ccrsf_tb_pkg::ROW_LIMIT / 2;
			n_rows = 2 * r;
			top_row = py - r;
		end
		for (i = 0; i < n_rows; i++) begin
			row = top_row + i;
			row_rec = '0;
			row_rec.span_color = fill_color;
			row_rec.last_row = (i == n_rows - 1);
			if (row >= 0 && row < int'(frame_height)) begin
				row_rec.row_visible = 1'b1;
				if (shape == ccrsf_tb_pkg::SHAPE_RECT) begin
					len = w;
					xofs = px;
				end else begin
					dy = r - i;
					radicand = r * r - dy * dy;
					half = 0;
					while ((half + 1) * (half + 1) <= radicand)
						half++;
					len = 2 * half;
					xofs = px - half;
				end
				if (xofs < 0) begin
					len += xofs;
					xofs = 0;
				end
				if (xofs + len >= int'(frame_width))
					len = int'(frame_width) - xofs;
				row_rec.span_length = (len > 0) ? 13'(len) : 13'd0;
				row_rec.span_address = 24'(row * int'(row_pitch) + xofs);
			end
			span_rows_q.push_back(row_rec);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ccrsf_tb_pkg::span_rec_t want;
		if (!arst_n) begin
			frame_width = ccrsf_pkg::FRAME_WIDTH_RST;
			frame_height = ccrsf_pkg::FRAME_HEIGHT_RST;
			row_pitch = ccrsf_pkg::ROW_PITCH_RST;
			fill_color = ccrsf_pkg::FILL_COLOR_RST;
		end else begin
			if (cmd.valid && cmd.ready)
				predict_spans(ccrsf_tb_pkg::shape_t'(cmd.op), int'(cmd.pos_x),
					int'(cmd.pos_y), int'(cmd.rect_width), int'(cmd.rect_height),
					int'(cmd.radius));
			if (span.valid && span.ready) begin
				if (span_rows_q.size() == 0) begin
					report_mismatch($sformatf("span %0d arrived with none expected",
						span_count));
				end else begin
					want = span_rows_q.pop_front();
					if (span.row_visible !== want.row_visible)
						report_mismatch($sformatf("span %0d row_visible: got %b, expected %b",
							span_count, span.row_visible, want.row_visible));
					if (span.span_address !== want.span_address)
						report_mismatch($sformatf("span %0d span_address: got %h, expected %h",
							span_count, span.span_address, want.span_address));
					if (span.span_length !== want.span_length)
						report_mismatch($sformatf("span %0d span_length: got %0d, expected %0d",
							span_count, span.span_length, want.span_length));
					if (span.span_color !== want.span_color)
						report_mismatch($sformatf("span %0d span_color: got %h, expected %h",
							span_count, span.span_color, want.span_color));
					if (span.last_row !== want.last_row)
						report_mismatch($sformatf("span %0d last_row: got %b, expected %b",
							span_count, span.last_row, want.last_row));
				end
				span_count++;
			end
			if (psel && penable && pwrite && pready) begin
				case (ccrsf_pkg::cfg_reg_t'(paddr[3:2]))
					ccrsf_pkg::REG_FRAME_WIDTH:  frame_width = pwdata[12:0];
					ccrsf_pkg::REG_FRAME_HEIGHT: frame_height = pwdata[12:0];
					ccrsf_pkg::REG_ROW_PITCH:    row_pitch = pwdata[12:0];
					ccrsf_pkg::REG_FILL_COLOR:   fill_color = pwdata;
					default: ;
				endcase
			end
			if (flush && !flushed) begin
				flushed = 1;
				if (span_rows_q.size() != 0)
					report_mismatch($sformatf("%0d expected spans never arrived",
						span_rows_q.size()));
			end
		end
		pending = span_rows_q.size();
	end

endmodule

[tb/tb_top.sv]
// Top of the span rasterizer testbench: clock, reset, register writes, draw
// command stimulus and span back-pressure; the span_checker does the comparing.
// Depends on ccrsf_pkg, ccrsf_tb_pkg, the channel interfaces and span_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 64;
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int PHASES         = 5;
	localparam int PHASE_ITEMS    = 50;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [ccrsf_pkg::ADDR_W-1:0] paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;
	logic                         flush;
	int                           fail_count;
	int                           pending;
	int                           idle_cycles;
	int                           cur_fw;
	int                           cur_fh;
	int                           tx_gap_pct;
	int                           rx_gap_pct;
	bit                           rx_hold_req;

	ccrsf_cmd_if  cmd_ch();
	ccrsf_span_if span_ch();

	clipped_circle_rect_span_fill uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.span    (span_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	span_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.span       (span_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.flush      (flush),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 0;
	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (span_ch.valid && span_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int stall;
		span_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				span_ch.ready = 0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 0;
			end else if ($urandom_range(0, 99) < rx_gap_pct) begin
				span_ch.ready = 0;
				stall = $urandom_range(1, 16);
				repeat (stall - 1) @(negedge clk);
			end else begin
				span_ch.ready = 1;
			end
		end
	end

	task automatic write_reg(ccrsf_pkg::cfg_reg_t idx, logic [31:0] value);
		@(negedge clk);
		psel = 1;
		penable = 0;
		pwrite = 1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic drain();
		@(negedge clk);
		cmd_ch.valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(int fw, int fh, int pitch, logic [31:0] color);
		drain();
		write_reg(ccrsf_pkg::REG_FRAME_WIDTH, 32'(fw));
		write_reg(ccrsf_pkg::REG_FRAME_HEIGHT, 32'(fh));
		write_reg(ccrsf_pkg::REG_ROW_PITCH, 32'(pitch));
		write_reg(ccrsf_pkg::REG_FILL_COLOR, color);
		cur_fw = fw;
		cur_fh = fh;
	endtask

	task automatic send_cmd(ccrsf_tb_pkg::shape_t shape, int px, int py, int w, int h, int r);
		int gap;
		if ($urandom_range(0, 99) < tx_gap_pct) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			cmd_ch.valid = 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_ch.valid = 1;
		cmd_ch.op = shape;
		cmd_ch.pos_x = 13'(px);
		cmd_ch.pos_y = 13'(py);
		cmd_ch.rect_width = 13'(w);
		cmd_ch.rect_height = 7'(h);
		cmd_ch.radius = 6'(r);
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	function automatic int pick_dim();
		case ($urandom_range(0, 9))
			0: return 4096;
			1: return 1;
			2: return $urandom_range(1, 64);
			default: return $urandom_range(1, 4096);
		endcase
	endfunction

	initial begin
		int p, k, px, py, w, h, r;
		ccrsf_tb_pkg::shape_t shape;
		cmd_ch.valid = 0;
		cmd_ch.op = 0;
		cmd_ch.pos_x = '0;
		cmd_ch.pos_y = '0;
		cmd_ch.rect_width = '0;
		cmd_ch.rect_height = '0;
		cmd_ch.radius = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		flush = 0;
		rx_hold_req = 0;
		tx_gap_pct = 15;
		rx_gap_pct = 15;
		cur_fw = 640;
		cur_fh = 480;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset register values
		send_cmd(ccrsf_tb_pkg::SHAPE_RECT, 0, 0, 1, 1, 0);
		send_cmd(ccrsf_tb_pkg::SHAPE_RECT, 10, 10, 20, 0, 5);
		send_cmd(ccrsf_tb_pkg::SHAPE_CIRCLE, 100, 100, 0, 0, 0);
		send_cmd(ccrsf_tb_pkg::SHAPE_RECT, -10, 5, 30, 2, 0);
		send_cmd(ccrsf_tb_pkg::SHAPE_RECT, 630, 6, 20, 1, 0);
		send_cmd(ccrsf_tb_pkg::SHAPE_RECT, 50, 7, -5, 1, 0);
		send_cmd(ccrsf_tb_pkg::SHAPE_RECT, 700, 8, 10, 1, 0);
		send_cmd(ccrsf_tb_pkg::SHAPE_RECT, -4096, -4096, 4095, 1, 0);
		send_cmd(ccrsf_tb_pkg::SHAPE_RECT, 4095, 4095, -4096, 1, 0);
		send_cmd(ccrsf_tb_pkg::SHAPE_RECT, 20, -2, 4095, 4, 0);
		send_cmd(ccrsf_tb_pkg::SHAPE_RECT, -100, 477, 50, 64, 0);
		send_cmd(ccrsf_tb_pkg::SHAPE_CIRCLE, 320, 240, 0, 0, 32);
		send_cmd(ccrsf_tb_pkg::SHAPE_CIRCLE, 5, 20, 0, 0, 10);
		send_cmd(ccrsf_tb_pkg::SHAPE_CIRCLE, 635, 470, 0, 0, 12);
		send_cmd(ccrsf_tb_pkg::SHAPE_CIRCLE, -4096, 3, 0, 0, 1);
		send_cmd(ccrsf_tb_pkg::SHAPE_RECT, 0, 0, 8, 100, 0);
		send_cmd(ccrsf_tb_pkg::SHAPE_CIRCLE, 4095, 100, 0, 0, 40);

		configure(4096, 4096, 4096, 32'hFFFF_FFFF);
		send_cmd(ccrsf_tb_pkg::SHAPE_RECT, 0, 4095, 4095, 1, 0);
		send_cmd(ccrsf_tb_pkg::SHAPE_RECT, 4000, 4090, 200, 6, 0);
		send_cmd(ccrsf_tb_pkg::SHAPE_CIRCLE, 2048, 4090, 0, 0, 8);

		configure(1, 1, 1, 32'h0000_0000);
		send_cmd(ccrsf_tb_pkg::SHAPE_RECT, 0, 0, 5, 2, 0);
		send_cmd(ccrsf_tb_pkg::SHAPE_CIRCLE, 0, 0, 0, 0, 2);

		configure(0, 480, 0, 32'h1234_5678);
		send_cmd(ccrsf_tb_pkg::SHAPE_RECT, 3, 2, 10, 2, 0);

		configure(640, 0, 640, 32'h8765_4321);
		send_cmd(ccrsf_tb_pkg::SHAPE_CIRCLE, 100, 100, 0, 0, 3);

		for (p = 0; p < PHASES; p++) begin
			configure(pick_dim(), pick_dim(), pick_dim(), $urandom());
			case (p)
				0: begin tx_gap_pct = 20; rx_gap_pct = 20; end
				1: begin tx_gap_pct = 0; rx_gap_pct = 10; rx_hold_req = 1; end
				2: begin tx_gap_pct = 40; rx_gap_pct = 5; end
				3: begin tx_gap_pct = 0; rx_gap_pct = 30; end
				default: begin tx_gap_pct = 0; rx_gap_pct = 0; end
			endcase
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 2 && k == PHASE_ITEMS / 2)
					drain();
				shape = ccrsf_tb_pkg::shape_t'($urandom_range(0, 1));
				if ($urandom_range(0, 9) == 0) begin
					px = int'($urandom_range(0, 8191)) - 4096;
					py = int'($urandom_range(0, 8191)) - 4096;
				end else begin
					px = int'($urandom_range(0, cur_fw + 64)) - 32;
					py = int'($urandom_range(0, cur_fh + 64)) - 32;
					if (px > 4095)
						px = 4095;
					if (py > 4095)
						py = 4095;
				end
				case ($urandom_range(0, 9))
					0: w = int'($urandom_range(0, 8191)) - 4096;
					1: w = -int'($urandom_range(0, 16));
					default: w = $urandom_range(0, 160);
				endcase
				h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 6);
				r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32) : $urandom_range(0, 6);
				send_cmd(shape, px, py, w, h, r);
			end
		end

		drain();
		flush = 1;
		repeat (2) @(negedge clk);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

[files.f]
rtl/ccrsf_pkg.sv
rtl/ccrsf_if.sv
rtl/ccrsf_isqrt.sv
rtl/clipped_circle_rect_span_fill.sv
rtl/ccrsf_checker.sv
tb/ccrsf_tb_pkg.sv
tb/span_checker.sv
tb/tb_top.sv
